>>> design/tsc_pkg.sv
// shared types, codes and microcode program for the taylor series unit
`timescale 1ns / 1ps
package tsc_pkg;

	// fixed-point formats
	localparam int FRAC_BITS = 28;
	localparam int ARG_W     = 32;
	localparam int RES_W     = 42;
	localparam int MT_W      = 38;
	localparam int MT_LO_W   = 19;
	localparam int MT_HI_W   = MT_W - MT_LO_W;
	localparam int PROD_W    = MT_LO_W + ARG_W;
	localparam int ACC_W     = MT_W + ARG_W;
	localparam int QUOT_W    = ACC_W - 1 - FRAC_BITS;
	localparam int SUM_W     = 48;

	// term divider: eight quotient bits per step
	localparam int DIV_BITS   = 8;
	localparam int DIV_STEPS  = 6;
	localparam int DVD_W      = DIV_BITS * DIV_STEPS;
	localparam int DCNT_W     = 3;
	localparam logic [DCNT_W-1:0] DIV_LAST = DCNT_W'(DIV_STEPS - 1);

	localparam logic [4:0] HALF_TERMS_RST = 5'd6;

	// operation select
	localparam logic [1:0] REQ_COS = 2'd0;
	localparam logic [1:0] REQ_SIN = 2'd1;
	localparam logic [1:0] REQ_EXP = 2'd2;
	localparam logic [1:0] REQ_BAD = 2'd3;

	// status codes
	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_INVALID = 2'd1;
	localparam logic [1:0] ST_SAT     = 2'd2;

	// datapath operations
	localparam logic [2:0] OP_NOP      = 3'd0;
	localparam logic [2:0] OP_INIT     = 3'd1;
	localparam logic [2:0] OP_MUL_LO   = 3'd2;
	localparam logic [2:0] OP_MUL_HI   = 3'd3;
	localparam logic [2:0] OP_DIV_LOAD = 3'd4;
	localparam logic [2:0] OP_DIV_STEP = 3'd5;
	localparam logic [2:0] OP_TERM     = 3'd6;
	localparam logic [2:0] OP_FINISH   = 3'd7;

	// jump conditions
	localparam logic [1:0] JC_NONE    = 2'd0;
	localparam logic [1:0] JC_INVALID = 2'd1;
	localparam logic [1:0] JC_DIV     = 2'd2;
	localparam logic [1:0] JC_TERM    = 2'd3;

	// program steps
	localparam int PC_W = 3;
	localparam logic [PC_W-1:0] PC_INIT     = 3'd0;
	localparam logic [PC_W-1:0] PC_MUL_LO   = 3'd1;
	localparam logic [PC_W-1:0] PC_MUL_HI   = 3'd2;
	localparam logic [PC_W-1:0] PC_DIV_LOAD = 3'd3;
	localparam logic [PC_W-1:0] PC_DIV_STEP = 3'd4;
	localparam logic [PC_W-1:0] PC_TERM     = 3'd5;
	localparam logic [PC_W-1:0] PC_FINISH   = 3'd6;

	typedef struct packed {
		logic [1:0]              req_type;
		logic signed [ARG_W-1:0] arg;
	} req_t;

	typedef struct packed {
		logic signed [RES_W-1:0] result;
		logic [1:0]              status;
	} rsp_t;

	typedef struct packed {
		logic [2:0]      op;
		logic [1:0]      jc;
		logic [PC_W-1:0] target;
	} uword_t;

	typedef struct packed {
		logic       load;
		logic [2:0] op;
	} ctl_t;

	typedef struct packed {
		logic invalid;
		logic div_more;
		logic term_more;
	} dp_st_t;

	// microcode rom
	function automatic uword_t ucode(input logic [PC_W-1:0] pc);
		uword_t w;
		unique case (pc)
			PC_INIT:     w = '{op: OP_INIT,     jc: JC_INVALID, target: PC_FINISH};
			PC_MUL_LO:   w = '{op: OP_MUL_LO,   jc: JC_NONE,    target: PC_INIT};
			PC_MUL_HI:   w = '{op: OP_MUL_HI,   jc: JC_NONE,    target: PC_INIT};
			PC_DIV_LOAD: w = '{op: OP_DIV_LOAD, jc: JC_NONE,    target: PC_INIT};
			PC_DIV_STEP: w = '{op: OP_DIV_STEP, jc: JC_DIV,     target: PC_DIV_STEP};
			PC_TERM:     w = '{op: OP_TERM,     jc: JC_TERM,    target: PC_MUL_LO};
			default:     w = '{op: OP_FINISH,   jc: JC_NONE,    target: PC_INIT};
		endcase
		return w;
	endfunction

endpackage

>>> design/tsc_dp.sv
// datapath of the taylor series unit: shared multiplier, term divider, accumulator
`timescale 1ns / 1ps
module tsc_dp #(
	parameter int MAX_HALF_TERMS = 16
) (
	input  logic            clk,
	input  logic            arst_n,
	input  tsc_pkg::ctl_t   ctl,
	input  tsc_pkg::req_t   req,
	input  logic [4:0]      half_terms,
	output tsc_pkg::dp_st_t st,
	output tsc_pkg::rsp_t   rsp
);
	import tsc_pkg::*;

	localparam int KW = $clog2(2 * MAX_HALF_TERMS);
	localparam logic [KW-1:0] LAST_MAX = KW'(2 * MAX_HALF_TERMS - 1);
	localparam logic [MT_W-1:0] ONE_MT = MT_W'(1) << FRAC_BITS;
	localparam logic signed [SUM_W-1:0] ONE_SUM = SUM_W'(1) << FRAC_BITS;
	localparam logic signed [SUM_W-1:0] RES_MAX = (SUM_W'(1) << (RES_W - 1)) - SUM_W'(1);
	localparam logic signed [SUM_W-1:0] RES_MIN = -(SUM_W'(1) << (RES_W - 1));

	logic [1:0]              sel_q;
	logic signed [ARG_W-1:0] x_q;
	logic [ARG_W-1:0]        mx_q;
	logic                    negx_q;
	logic [KW-1:0]           k_q;
	logic [KW-1:0]           last_q;
	logic [MT_W-1:0]         mt_q;
	logic                    negt_q;
	logic signed [SUM_W-1:0] sum_q;
	logic [ACC_W-1:0]        acc_q;
	logic [DVD_W-1:0]        dvd_q;
	logic [KW-1:0]           rem_q;
	logic [DCNT_W-1:0]       dcnt_q;

	logic [KW-1:0]           last_n;
	logic [MT_LO_W-1:0]      mul_a;
	logic [PROD_W-1:0]       prod;
	logic [DVD_W-1:0]        dvd_n;
	logic [KW-1:0]           rem_n;
	logic [MT_W-1:0]         mt_n;
	logic                    negt_n;
	logic                    add_en;
	logic                    flip;
	logic signed [SUM_W-1:0] mag;
	logic signed [SUM_W-1:0] tv;

	// last term index from the register, clamped to the supported range
	always_comb begin
		if (half_terms == 5'd0) begin
			last_n = KW'(1);
		end else if (int'(half_terms) > MAX_HALF_TERMS) begin
			last_n = LAST_MAX;
		end else begin
			last_n = KW'({half_terms, 1'b0} - 6'd1);
		end
	end

	// shared multiplier: one half of the term magnitude by |x|
	assign mul_a = (ctl.op == OP_MUL_HI) ? MT_LO_W'(mt_q[MT_W-1:MT_LO_W]) : mt_q[MT_LO_W-1:0];
	assign prod  = PROD_W'(mul_a) * PROD_W'(mx_q);

	// restoring division by k, eight quotient bits per step
	always_comb begin
		logic [KW:0]       r;
		logic [DVD_W-1:0]  d;
		r = {1'b0, rem_q};
		d = dvd_q;
		for (int i = 0; i < DIV_BITS; i++) begin
			r = {r[KW-1:0], d[DVD_W-1]};
			d = {d[DVD_W-2:0], 1'b0};
			if (r >= {1'b0, k_q}) begin
				r = r - {1'b0, k_q};
				d[0] = 1'b1;
			end
		end
		rem_n = r[KW-1:0];
		dvd_n = d;
	end

	// next term and whether it enters the sum for the selected series
	assign mt_n   = dvd_q[MT_W-1:0];
	assign negt_n = negt_q ^ negx_q;
	assign flip   = (sel_q != REQ_EXP) && k_q[1];
	assign mag    = SUM_W'(mt_n);
	assign tv     = (negt_n ^ flip) ? -mag : mag;
	always_comb begin
		case (sel_q)
			REQ_COS: add_en = ~k_q[0];
			REQ_SIN: add_en = k_q[0] && (k_q != KW'(1));
			default: add_en = 1'b1;
		endcase
	end

	// request capture
	always_ff @(posedge clk) begin
		if (ctl.load) begin
			sel_q <= req.req_type;
			x_q   <= req.arg;
		end
	end

	// sequence counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k_q    <= '0;
			dcnt_q <= '0;
		end else begin
			case (ctl.op)
				OP_INIT:     k_q <= KW'(1);
				OP_TERM:     k_q <= k_q + KW'(1);
				OP_DIV_LOAD: dcnt_q <= '0;
				OP_DIV_STEP: dcnt_q <= dcnt_q + DCNT_W'(1);
				default: ;
			endcase
		end
	end

	// arithmetic registers, driven by the current control word
	always_ff @(posedge clk) begin
		case (ctl.op)
			OP_INIT: begin
				negx_q <= x_q[ARG_W-1];
				mx_q   <= x_q[ARG_W-1] ? ARG_W'(-x_q) : ARG_W'(x_q);
				last_q <= last_n;
				mt_q   <= ONE_MT;
				negt_q <= 1'b0;
				sum_q  <= (sel_q == REQ_SIN) ? SUM_W'(x_q) : ONE_SUM;
			end
			OP_MUL_LO: begin
				acc_q <= ACC_W'(prod);
			end
			OP_MUL_HI: begin
				acc_q <= acc_q + (ACC_W'(prod) << MT_LO_W);
			end
			OP_DIV_LOAD: begin
				dvd_q <= DVD_W'(acc_q[ACC_W-2:FRAC_BITS]);
				rem_q <= '0;
			end
			OP_DIV_STEP: begin
				dvd_q <= dvd_n;
				rem_q <= rem_n;
			end
			OP_TERM: begin
				mt_q   <= mt_n;
				negt_q <= negt_n;
				if (add_en) begin
					sum_q <= sum_q + tv;
				end
			end
			default: ;
		endcase
	end

	// status to the sequencer
	assign st.invalid   = (sel_q == REQ_BAD);
	assign st.div_more  = (dcnt_q != DIV_LAST);
	assign st.term_more = (k_q != last_q);

	// final value with saturation
	always_comb begin
		if (sel_q == REQ_BAD) begin
			rsp.result = '0;
			rsp.status = ST_INVALID;
		end else if (sum_q > RES_MAX) begin
			rsp.result = RES_MAX[RES_W-1:0];
			rsp.status = ST_SAT;
		end else if (sum_q < RES_MIN) begin
			rsp.result = RES_MIN[RES_W-1:0];
			rsp.status = ST_SAT;
		end else begin
			rsp.result = sum_q[RES_W-1:0];
			rsp.status = ST_OK;
		end
	end

endmodule

>>> design/taylor_series_sin_cos_exp.sv
// top level of the taylor series unit for cosine, sine and exponential.
// A request (req_type, arg in Q4.28) is taken at a clock edge where start is high and busy
// is low; one result (Q14.28, saturated, with status) appears on rsp with done high for exactly
// one cycle and cannot be held off. The series is summed term by term, each term being
// the previous one times |x| over k. A microcode sequencer drives one shared 19x32 multiplier
// (two passes per term) and a divider by k that yields eight quotient bits per cycle. With
// h the clamped half-term count, busy stays high while the 2h-1 terms are summed; an invalid
// select skips the terms. A new request may be accepted in the cycle its predecessor's result
// shows. half_terms is written through cfg_valid/cfg_ready while the unit is idle.
`timescale 1ns / 1ps
module taylor_series_sin_cos_exp #(
	parameter int MAX_HALF_TERMS = 16
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	output logic           busy,
	input  tsc_pkg::req_t  req,
	output logic           done,
	output tsc_pkg::rsp_t  rsp,
	input  logic           cfg_valid,
	output logic           cfg_ready,
	input  logic [4:0]     cfg_data
);
	import tsc_pkg::*;

	logic            busy_q;
	logic            done_q;
	logic [PC_W-1:0] pc_q;
	logic [4:0]      half_terms_q;
	rsp_t            rsp_q;

	uword_t  uw;
	ctl_t    ctl;
	dp_st_t  st;
	rsp_t    dp_rsp;
	logic    accept;
	logic    taken;

	assign accept    = start && !busy_q;
	assign cfg_ready = !busy_q;

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			half_terms_q <= HALF_TERMS_RST;
		end else if (cfg_valid && cfg_ready) begin
			half_terms_q <= cfg_data;
		end
	end

	// microcode fetch and jump decision
	assign uw = ucode(pc_q);
	always_comb begin
		unique case (uw.jc)
			JC_INVALID: taken = st.invalid;
			JC_DIV:     taken = st.div_more;
			JC_TERM:    taken = st.term_more;
			default:    taken = 1'b0;
		endcase
	end

	assign ctl.load = accept;
	assign ctl.op   = busy_q ? uw.op : OP_NOP;

	// sequencer: step counter and run flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			pc_q   <= PC_INIT;
		end else begin
			done_q <= 1'b0;
			if (accept) begin
				busy_q <= 1'b1;
				pc_q   <= PC_INIT;
			end else if (busy_q) begin
				if (uw.op == OP_FINISH) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					pc_q <= taken ? uw.target : pc_q + PC_W'(1);
				end
			end
		end
	end

	// result beat register
	always_ff @(posedge clk) begin
		if (busy_q && uw.op == OP_FINISH) begin
			rsp_q <= dp_rsp;
		end
	end

	tsc_dp #(
		.MAX_HALF_TERMS(MAX_HALF_TERMS)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctl        (ctl),
		.req        (req),
		.half_terms (half_terms_q),
		.st         (st),
		.rsp        (dp_rsp)
	);

	assign busy = busy_q;
	assign done = done_q;
	assign rsp  = rsp_q;

`ifndef SYNTHESIS
	// a result beat only follows a busy cycle
	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> $past(busy_q))
		else $error("result beat without a running request");

	// the run ends exactly with a result beat
	a_busy_fall_done: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy_q) |-> done_q)
		else $error("request ended without a result beat");

	// an accepted request starts a run at the program entry
	a_accept_runs: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (busy_q && pc_q == PC_INIT))
		else $error("accepted request did not start the program");

	// an invalid select always reports a zero result
	a_invalid_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done_q && rsp_q.status == ST_INVALID) |-> (rsp_q.result == '0))
		else $error("invalid select with nonzero result");
`endif

endmodule

>>> bench/series_checker.sv
// checker for the taylor series unit: predicts each result and compares it on arrival
`timescale 1ns / 1ps
module series_checker #(
	parameter int MAX_HALF_TERMS = 16
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic          busy,
	input  tsc_pkg::req_t req,
	input  logic          done,
	input  tsc_pkg::rsp_t rsp,
	input  logic          cfg_valid,
	input  logic          cfg_ready,
	input  logic [4:0]    cfg_data,
	output int            failures,
	output int            results_seen
);
	import tsc_pkg::*;

	localparam longint RES_HI = (longint'(1) << (RES_W - 1)) - 1;
	localparam longint RES_LO = -RES_HI - 1;

	// local copy of the half-term register
	logic [4:0] half_terms_q;
	// results still owed by the unit, oldest first
	rsp_t pending_results[$];

	// sum the truncated series the way the unit does, term by term on magnitudes
	function automatic rsp_t series_value(input req_t item, input logic [4:0] terms_reg);
		rsp_t        r;
		logic        neg_x;
		logic        neg_term;
		logic [32:0] mag_x;
		logic [63:0] mag_term;
		logic [95:0] prod;
		longint      term;
		longint      sum;
		int          h;
		int          last;
		r.result = '0;
		r.status = ST_OK;
		if (item.req_type == REQ_BAD) begin
			r.status = ST_INVALID;
			return r;
		end
		h = int'(terms_reg);
		if (h > MAX_HALF_TERMS)
			h = MAX_HALF_TERMS;
		if (h == 0)
			h = 1;
		last = 2 * h - 1;
		neg_x = item.arg[ARG_W-1];
		mag_x = neg_x ? (33'd0 - {item.arg[ARG_W-1], item.arg}) : {1'b0, item.arg};
		sum = (item.req_type == REQ_SIN) ? longint'(item.arg) : (longint'(1) << FRAC_BITS);
		mag_term = 64'd1 << FRAC_BITS;
		neg_term = 1'b0;
		for (int k = 1; k <= last; k++) begin
			prod = mag_term * mag_x;
			mag_term = prod[FRAC_BITS +: 64] / 64'(k);
			neg_term = neg_term ^ neg_x;
			term = neg_term ? -longint'(mag_term) : longint'(mag_term);
			case (item.req_type)
				REQ_COS: begin
					if (k % 2 == 0)
						sum += ((k / 2) % 2 != 0) ? -term : term;
				end
				REQ_SIN: begin
					if (k % 2 == 1 && k >= 3)
						sum += (((k - 1) / 2) % 2 != 0) ? -term : term;
				end
				default: begin
					sum += term;
				end
			endcase
		end
		// clip to the 42-bit output range
		if (sum > RES_HI) begin
			sum = RES_HI;
			r.status = ST_SAT;
		end else if (sum < RES_LO) begin
			sum = RES_LO;
			r.status = ST_SAT;
		end
		r.result = sum[RES_W-1:0];
		return r;
	endfunction

	// watch config, request and result beats
	always @(posedge clk or negedge arst_n) begin : watch
		rsp_t want;
		if (!arst_n) begin
			half_terms_q = HALF_TERMS_RST;
			pending_results.delete();
			failures = 0;
			results_seen = 0;
		end else begin
			// result beat against the oldest prediction
			if (done) begin
				if (pending_results.size() == 0) begin
					failures++;
					if (failures <= 10)
						$display("unexpected result beat: result %h st %0d", rsp.result,
							rsp.status);
				end else begin
					want = pending_results.pop_front();
					results_seen++;
					if (rsp.result !== want.result || rsp.status !== want.status) begin
						failures++;
						if (failures <= 10)
							$display("mismatch: expected result %h st %0d, got result %h st %0d",
								want.result, want.status, rsp.result, rsp.status);
					end
				end
			end
			if (cfg_valid && cfg_ready)
				half_terms_q = cfg_data;
			if (start && !busy)
				pending_results.push_back(series_value(req, half_terms_q));
		end
	end

endmodule

>>> bench/testbench.sv
// top of the taylor series bench: clock, reset, request and config stimulus, verdict
`timescale 1ns / 1ps
module testbench;
	import tsc_pkg::*;

	localparam int CYCLE_LIMIT = 1500000;
	localparam int DRAIN       = 16;
	localparam int PHASES      = 12;
	localparam int PHASE_ITEMS = 85;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       start = 1'b0;
	logic       busy;
	req_t       req = '0;
	logic       done;
	rsp_t       rsp;
	logic       cfg_valid = 1'b0;
	logic       cfg_ready;
	logic [4:0] cfg_data = '0;

	int failures;
	int results_seen;
	int issued = 0;
	int idle_max = 6;
	int cycle_count = 0;

	taylor_series_sin_cos_exp DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.req       (req),
		.done      (done),
		.rsp       (rsp),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	series_checker u_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.req          (req),
		.done         (done),
		.rsp          (rsp),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_data     (cfg_data),
		.failures     (failures),
		.results_seen (results_seen)
	);

	// 8 ns clock
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// run timeout
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

	// argument corners: zero, both extremes, plus and minus one, one lsb either way
	function automatic logic signed [ARG_W-1:0] corner_arg(input int idx);
		case (idx)
			0:       return 32'sh0000_0000;
			1:       return 32'sh7FFF_FFFF;
			2:       return 32'sh8000_0000;
			3:       return 32'sh1000_0000;
			4:       return 32'shF000_0000;
			5:       return 32'sh0000_0001;
			default: return 32'shFFFF_FFFF;
		endcase
	endfunction

	function automatic req_t make_req(input logic [1:0] op, input logic signed [ARG_W-1:0] x);
		req_t item;
		item.req_type = op;
		item.arg = x;
		return item;
	endfunction

	// mostly valid selects, an invalid one now and then
	function automatic logic [1:0] random_op();
		int pick;
		pick = $urandom_range(0, 9);
		if (pick == 0)
			return REQ_BAD;
		case (pick % 3)
			0:       return REQ_COS;
			1:       return REQ_SIN;
			default: return REQ_EXP;
		endcase
	endfunction

	function automatic logic signed [ARG_W-1:0] random_arg();
		if ($urandom_range(0, 7) == 0)
			return corner_arg($urandom_range(0, 6));
		return $urandom();
	endfunction

	// one request beat after a random idle gap; start stays high into the next beat
	task automatic send_request(input req_t item);
		int gap;
		gap = $urandom_range(0, idle_max);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		req <= item;
		@(posedge clk);
		while (busy) @(posedge clk);
		issued++;
	endtask

	// drain the unit, then write the half-term register
	task automatic write_half_terms(input logic [4:0] value);
		start <= 1'b0;
		wait (results_seen == issued);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= value;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
	endtask

	initial begin : stimulus
		logic [4:0] ht;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed corners at the reset half-term count
		for (int i = 0; i < 7; i++) begin
			send_request(make_req(REQ_COS, corner_arg(i)));
			send_request(make_req(REQ_SIN, corner_arg(i)));
			send_request(make_req(REQ_EXP, corner_arg(i)));
		end
		send_request(make_req(REQ_BAD, corner_arg(1)));
		send_request(make_req(REQ_BAD, corner_arg(2)));

		// random phases, each with its own half-term count and idle pattern
		for (int phase = 0; phase < PHASES; phase++) begin
			case (phase)
				0:       ht = 5'd0;
				1:       ht = 5'd31;
				2:       ht = 5'd1;
				3:       ht = 5'd17;
				4:       ht = 5'd16;
				5:       ht = 5'd2;
				default: ht = 5'($urandom_range(0, 8));
			endcase
			write_half_terms(ht);
			idle_max = ($urandom_range(0, 3) == 0) ? 0 : 6;
			repeat (PHASE_ITEMS) send_request(make_req(random_op(), random_arg()));
		end

		start <= 1'b0;
		wait (results_seen == issued);
		repeat (DRAIN) @(posedge clk);
		if (failures == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule

>>> taylor_series_sin_cos_exp.f
design/tsc_pkg.sv
design/tsc_dp.sv
design/taylor_series_sin_cos_exp.sv
bench/series_checker.sv
bench/testbench.sv
